[src/sfcq_pkg.sv]
// Shared types and constants of the sample frame check queue.
package sfcq_pkg;

  // Default sizes of the frame ring.
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int FRAME_BYTES_DEF = 27;

  // Input operation codes.
  localparam logic [2:0] OP_EDGE = 3'd0;
  localparam logic [2:0] OP_BYTE = 3'd1;
  localparam logic [2:0] OP_POP  = 3'd2;
  localparam logic [2:0] OP_STOP = 3'd3;
  localparam logic [2:0] OP_READ = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_STAT  = 2'd2;

  // Statistic indexes; the fault flag is not a counter.
  localparam int         CNT_NUM     = 7;
  localparam logic [2:0] CNT_GOOD    = 3'd0;
  localparam logic [2:0] CNT_BAD     = 3'd1;
  localparam logic [2:0] CNT_DROPS   = 3'd2;
  localparam logic [2:0] CNT_PEAK    = 3'd3;
  localparam logic [2:0] CNT_EDGES   = 3'd4;
  localparam logic [2:0] CNT_BUSY    = 3'd5;
  localparam logic [2:0] CNT_DISCARD = 3'd6;
  localparam logic [2:0] STAT_FAULT  = 3'd7;

  // Frame header check and bad streak limit.
  localparam logic [7:0] HDR_MASK  = 8'hF0;
  localparam logic [7:0] HDR_GOOD  = 8'hC0;
  localparam logic [1:0] BAD_LIMIT = 2'd3;

  // Command queue between front and back, and output queue.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_EDGE,
    CMD_BYTE,
    CMD_POP,
    CMD_STOP,
    CMD_READ
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  data_byte;
    logic [63:0] time_stamp;
    logic [2:0]  stat_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  frame_byte;
    logic [31:0] frame_sequence;
    logic [63:0] frame_time;
    logic        last_of_run;
    logic [31:0] stat_value;
    logic        fault_latched;
  } result_t;

endpackage

[src/sfcq_front.sv]
// Front end: input handshake, enable register, op decoding and the command queue.
module sfcq_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        op,
  input  logic [7:0]        data_byte,
  input  logic [63:0]       time_stamp,
  input  logic [2:0]        stat_index,
  output logic              cmd_valid,
  output sfcq_pkg::cmd_t    cmd,
  input  logic              cmd_take
);
  import sfcq_pkg::*;

  logic                  capture_enable;
  cmd_t                  cmdq [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] count;
  logic                  accept;
  logic                  keep;
  logic                  push;
  cmd_t                  decoded;

  assign in_stall  = (count == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign accept    = in_valid && !in_stall;
  assign cmd_valid = (count != '0);
  assign cmd       = cmdq[rd_ptr];

  // Ready edges are dropped here while capture is disabled; unused codes never
  // reach the back end.
  always_comb begin
    decoded.data_byte  = data_byte;
    decoded.time_stamp = time_stamp;
    decoded.stat_index = stat_index;
    decoded.op         = CMD_EDGE;
    keep               = 1'b1;
    unique case (op)
      OP_EDGE: begin
        decoded.op = CMD_EDGE;
        keep       = capture_enable;
      end
      OP_BYTE: decoded.op = CMD_BYTE;
      OP_POP:  decoded.op = CMD_POP;
      OP_STOP: decoded.op = CMD_STOP;
      OP_READ: decoded.op = CMD_READ;
      default: keep = 1'b0;
    endcase
  end

  assign push = accept && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enable <= 1'b0;
    end else if (cfg_we) begin
      capture_enable <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (push && !cmd_take) begin
        count <= count + 1'b1;
      end else if (cmd_take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmdq[wr_ptr] <= decoded;
    end
  end

endmodule

[src/sfcq_back.sv]
// Back end: capture, frame checks, frame ring memory, statistics and pop reads.
module sfcq_back #(
  parameter int QUEUE_DEPTH = sfcq_pkg::QUEUE_DEPTH_DEF,
  parameter int FRAME_BYTES = sfcq_pkg::FRAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  input  sfcq_pkg::cmd_t                  cmd,
  output logic                            cmd_take,
  input  logic [sfcq_pkg::OUTQ_CNT_W-1:0] out_level,
  output logic                            res_push,
  output sfcq_pkg::result_t               res
);
  import sfcq_pkg::*;

  // One spare slot means the slot being filled never holds a stored frame, so
  // bytes go straight into the ring while they arrive.
  localparam int SLOTS  = QUEUE_DEPTH + 1;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TOTAL  = SLOTS * FRAME_BYTES;
  localparam int AW     = $clog2(TOTAL);
  localparam int IDX_W  = $clog2(FRAME_BYTES + 1);

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_POP = 2'b10
  } state_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [63:0] stamp;
  } meta_t;

  state_t            state;
  logic [7:0]        ring_mem [TOTAL];
  meta_t             meta_mem [SLOTS];
  logic [7:0]        mem_q;
  meta_t             meta_q;
  logic [31:0]       counters [CNT_NUM];
  logic [FILL_W-1:0] fill;
  logic [SLOT_W-1:0] wr_slot;
  logic [SLOT_W-1:0] rd_slot;
  logic [AW-1:0]     wr_base;
  logic [AW-1:0]     rd_base;
  logic [AW-1:0]     pop_addr;
  logic [IDX_W-1:0]  pop_cnt;
  logic              cap_open;
  logic              cap_tainted;
  logic [IDX_W-1:0]  cap_idx;
  logic [31:0]       cap_seq;
  logic [63:0]       cap_time;
  logic              first_good;
  logic [1:0]        bad_run;
  logic              fault;

  logic              s1_valid;
  logic [1:0]        s1_kind;
  logic [31:0]       s1_seq;
  logic [63:0]       s1_time;
  logic              s1_last;
  logic [31:0]       s1_stat;
  logic              s1_fault;

  logic [OUTQ_CNT_W:0] room_used;
  logic              credit;
  logic              issue_pop;
  logic              byte_hdr_good;
  logic              frame_good;
  logic              last_byte;
  logic              ring_full;
  logic [1:0]        run_inc;
  logic              ring_we;
  logic              meta_we;
  logic [AW-1:0]     ring_waddr;
  logic [SLOT_W-1:0] wr_slot_next;
  logic [SLOT_W-1:0] rd_slot_next;
  logic [AW-1:0]     wr_base_next;
  logic [AW-1:0]     rd_base_next;
  logic              pop_last;
  logic [31:0]       stat_sel;

  // A command or a pop read is issued only when its result is sure of a place
  // in the output queue.
  assign room_used = {1'b0, out_level} + {{OUTQ_CNT_W{1'b0}}, s1_valid};
  assign credit    = room_used < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH);
  assign cmd_take  = (state == ST_RUN) && cmd_valid && credit;
  assign issue_pop = (state == ST_POP) && credit;

  assign byte_hdr_good = (cmd.data_byte & HDR_MASK) == HDR_GOOD;
  assign frame_good    = (cap_idx == '0) ? byte_hdr_good : first_good;
  assign last_byte     = (cap_idx == IDX_W'(FRAME_BYTES - 1));
  assign ring_full     = (fill == FILL_W'(QUEUE_DEPTH));
  assign run_inc       = (bad_run < BAD_LIMIT) ? bad_run + 2'd1 : bad_run;
  assign ring_we       = cmd_take && (cmd.op == CMD_BYTE) && cap_open;
  assign meta_we       = ring_we && last_byte && !cap_tainted && frame_good && !ring_full;
  assign ring_waddr    = wr_base + AW'(cap_idx);
  assign pop_last      = (pop_cnt == IDX_W'(FRAME_BYTES - 1));

  assign wr_slot_next = (wr_slot == SLOT_W'(SLOTS - 1)) ? '0 : wr_slot + 1'b1;
  assign rd_slot_next = (rd_slot == SLOT_W'(SLOTS - 1)) ? '0 : rd_slot + 1'b1;
  assign wr_base_next = (wr_base == AW'(TOTAL - FRAME_BYTES)) ? '0
                                                              : wr_base + AW'(FRAME_BYTES);
  assign rd_base_next = (rd_base == AW'(TOTAL - FRAME_BYTES)) ? '0
                                                              : rd_base + AW'(FRAME_BYTES);

  assign stat_sel = (cmd.stat_index == STAT_FAULT) ? {31'd0, fault}
                                                   : counters[cmd.stat_index];

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= cmd.data_byte;
    end
    mem_q <= ring_mem[pop_addr];
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[wr_slot] <= '{seq: cap_seq, stamp: cap_time};
    end
    meta_q <= meta_mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_RUN;
      s1_valid    <= 1'b0;
      fill        <= '0;
      wr_slot     <= '0;
      rd_slot     <= '0;
      wr_base     <= '0;
      rd_base     <= '0;
      cap_open    <= 1'b0;
      cap_tainted <= 1'b0;
      cap_idx     <= '0;
      bad_run     <= '0;
      fault       <= 1'b0;
      for (int i = 0; i < CNT_NUM; i++) begin
        counters[i] <= '0;
      end
    end else begin
      s1_valid <= 1'b0;
      unique case (state)
        ST_RUN: begin
          if (cmd_take) begin
            unique case (cmd.op)
              CMD_EDGE: begin
                counters[CNT_EDGES] <= counters[CNT_EDGES] + 32'd1;
                if (!fault) begin
                  if (cap_open) begin
                    counters[CNT_BUSY] <= counters[CNT_BUSY] + 32'd1;
                    cap_tainted        <= 1'b1;
                  end else begin
                    cap_open    <= 1'b1;
                    cap_tainted <= 1'b0;
                    cap_idx     <= '0;
                    cap_time    <= cmd.time_stamp;
                    cap_seq     <= counters[CNT_EDGES] + 32'd1;
                  end
                end
              end
              CMD_BYTE: begin
                if (cap_open) begin
                  if (cap_idx == '0) begin
                    first_good <= byte_hdr_good;
                  end
                  if (last_byte) begin
                    cap_open    <= 1'b0;
                    cap_tainted <= 1'b0;
                    cap_idx     <= '0;
                    if (!cap_tainted) begin
                      if (frame_good) begin
                        bad_run            <= '0;
                        counters[CNT_GOOD] <= counters[CNT_GOOD] + 32'd1;
                        if (ring_full) begin
                          counters[CNT_DROPS] <= counters[CNT_DROPS] + 32'd1;
                        end else begin
                          fill    <= fill + 1'b1;
                          wr_slot <= wr_slot_next;
                          wr_base <= wr_base_next;
                          if (32'(fill) + 32'd1 > counters[CNT_PEAK]) begin
                            counters[CNT_PEAK] <= 32'(fill) + 32'd1;
                          end
                        end
                      end else begin
                        counters[CNT_BAD] <= counters[CNT_BAD] + 32'd1;
                        bad_run           <= run_inc;
                        if (run_inc == BAD_LIMIT) begin
                          fault <= 1'b1;
                        end
                      end
                    end
                  end else begin
                    cap_idx <= cap_idx + 1'b1;
                  end
                end
              end
              CMD_POP: begin
                if (fill == '0) begin
                  s1_valid <= 1'b1;
                  s1_kind  <= KIND_EMPTY;
                  s1_seq   <= '0;
                  s1_time  <= '0;
                  s1_last  <= 1'b1;
                  s1_stat  <= '0;
                  s1_fault <= fault;
                end else begin
                  state    <= ST_POP;
                  pop_addr <= rd_base;
                  pop_cnt  <= '0;
                end
              end
              CMD_STOP: begin
                counters[CNT_DISCARD] <= counters[CNT_DISCARD] + 32'(fill)
                                         + 32'(cap_open);
                fill        <= '0;
                wr_slot     <= '0;
                rd_slot     <= '0;
                wr_base     <= '0;
                rd_base     <= '0;
                cap_open    <= 1'b0;
                cap_tainted <= 1'b0;
                cap_idx     <= '0;
                fault       <= 1'b0;
                bad_run     <= '0;
              end
              CMD_READ: begin
                s1_valid <= 1'b1;
                s1_kind  <= KIND_STAT;
                s1_seq   <= '0;
                s1_time  <= '0;
                s1_last  <= 1'b1;
                s1_stat  <= stat_sel;
                s1_fault <= fault;
              end
              default: begin
              end
            endcase
          end
        end
        ST_POP: begin
          if (issue_pop) begin
            s1_valid <= 1'b1;
            s1_kind  <= KIND_BYTE;
            s1_seq   <= meta_q.seq;
            s1_time  <= meta_q.stamp;
            s1_last  <= pop_last;
            s1_stat  <= '0;
            s1_fault <= fault;
            pop_addr <= pop_addr + 1'b1;
            pop_cnt  <= pop_cnt + 1'b1;
            if (pop_last) begin
              state   <= ST_RUN;
              rd_slot <= rd_slot_next;
              rd_base <= rd_base_next;
              fill    <= fill - 1'b1;
            end
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  // The frame byte comes from the registered read of the ring memory, in step with the other fields of its result.
  assign res_push           = s1_valid;
  assign res.kind           = s1_kind;
  assign res.frame_byte     = (s1_kind == KIND_BYTE) ? mem_q : 8'd0;
  assign res.frame_sequence = s1_seq;
  assign res.frame_time     = s1_time;
  assign res.last_of_run    = s1_last;
  assign res.stat_value     = s1_stat;
  assign res.fault_latched  = s1_fault;

endmodule

[src/sfcq_out.sv]
// Output queue that holds result words until the receiver takes them.
module sfcq_out (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            res_push,
  input  sfcq_pkg::result_t               res,
  output logic [sfcq_pkg::OUTQ_CNT_W-1:0] level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sfcq_pkg::result_t               out_word
);
  import sfcq_pkg::*;

  result_t               outq [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr;
  logic [OUTQ_PTR_W-1:0] rd_ptr;
  logic [OUTQ_CNT_W-1:0] count;
  logic                  take;

  assign level     = count;
  assign out_valid = (count != '0);
  assign out_word  = outq[rd_ptr];
  assign take      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (res_push && !take) begin
        count <= count + 1'b1;
      end else if (take && !res_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      outq[wr_ptr] <= res;
    end
  end

endmodule

[src/sample_frame_check_queue.sv]
// Top level of the sample frame check queue.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall    op, data_byte, time_stamp, stat_index
//   out      output     out_valid / out_stall  kind, frame_byte, frame_sequence,
//                                              frame_time, last_of_run, stat_value,
//                                              fault_latched
//   cfg      input      cfg_we               cfg_wdata (capture_enable)
//
// Every kept word (not an edge while capture is disabled, nor an unused code) goes into a
// two-entry command queue; the back end executes one command per cycle while the output
// queue has room, and a pop of a stored frame holds it while it reads the frame out, one
// byte a cycle as output room allows, through the ring memory's read port. The first result
// of a word passes the command queue, the back end's result register and the output queue
// before it is offered. Reset is synchronous and needs no clearing pass. A stalled output
// fills the four-word output queue, then holds the back end, then stalls the input.
module sample_frame_check_queue #(
  parameter int QUEUE_DEPTH = sfcq_pkg::QUEUE_DEPTH_DEF,
  parameter int FRAME_BYTES = sfcq_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [7:0]  data_byte,
  input  logic [63:0] time_stamp,
  input  logic [2:0]  stat_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  frame_byte,
  output logic [31:0] frame_sequence,
  output logic [63:0] frame_time,
  output logic        last_of_run,
  output logic [31:0] stat_value,
  output logic        fault_latched
);
  import sfcq_pkg::*;

  logic                  cmd_valid;
  cmd_t                  cmd;
  logic                  cmd_take;
  logic                  res_push;
  result_t               res;
  logic [OUTQ_CNT_W-1:0] out_level;
  result_t               out_word;

  sfcq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .data_byte  (data_byte),
    .time_stamp (time_stamp),
    .stat_index (stat_index),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  sfcq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_level (out_level),
    .res_push  (res_push),
    .res       (res)
  );

  sfcq_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_push  (res_push),
    .res       (res),
    .level     (out_level),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign kind           = out_word.kind;
  assign frame_byte     = out_word.frame_byte;
  assign frame_sequence = out_word.frame_sequence;
  assign frame_time     = out_word.frame_time;
  assign last_of_run    = out_word.last_of_run;
  assign stat_value     = out_word.stat_value;
  assign fault_latched  = out_word.fault_latched;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the sample frame check queue, with its own frame ring predictor.
module tb_top;
  import sfcq_pkg::*;

  localparam int QD = QUEUE_DEPTH_DEF;
  localparam int FB = FRAME_BYTES_DEF;
  localparam int OP_LAST = 7;
  localparam int IDLE_PCT = 32;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 600;
  localparam int QUIET_LIMIT = 3000;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  data;
    logic [63:0] stamp;
    logic [2:0]  sel;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  op = '0;
  logic [7:0]  data_byte = '0;
  logic [63:0] time_stamp = '0;
  logic [2:0]  stat_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  frame_byte;
  logic [31:0] frame_sequence;
  logic [63:0] frame_time;
  logic        last_of_run;
  logic [31:0] stat_value;
  logic        fault_latched;

  sample_frame_check_queue DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .data_byte(data_byte),
    .time_stamp(time_stamp), .stat_index(stat_index),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .frame_byte(frame_byte),
    .frame_sequence(frame_sequence), .frame_time(frame_time), .last_of_run(last_of_run),
    .stat_value(stat_value), .fault_latched(fault_latched)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting to be offered, and the result words expected back.
  stim_t   stim_words[$];
  result_t expected_words[$];
  stim_t   on_bus;

  // Predictor state.
  logic [7:0]  ring_mem [QD*FB];
  logic [31:0] ring_seq [QD];
  logic [63:0] ring_tm  [QD];
  logic [7:0]  cap_buf  [FB];
  logic [31:0] stat_cnt [CNT_NUM] = '{default: '0};
  int          wr_cnt = 0;
  int          rd_cnt = 0;
  int          cap_idx = 0;
  logic        cap_open = 1'b0;
  logic        cap_taint = 1'b0;
  logic [31:0] cap_seq = '0;
  logic [63:0] cap_tm = '0;
  logic [1:0]  bad_row = '0;
  logic        fault = 1'b0;
  logic        cap_en = 1'b0;

  // Run bookkeeping.
  int mismatches = 0;
  int words_taken = 0;
  int words_checked = 0;
  int frames_popped = 0;
  int fault_events = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  function automatic int ring_fill();
    return (wr_cnt + 2 * QD - rd_cnt) % (2 * QD);
  endfunction

  function automatic result_t make_word(logic [1:0] k, logic [7:0] b, logic [31:0] s,
                                        logic [63:0] t, logic l, logic [31:0] v);
    result_t r;
    r.kind = k;
    r.frame_byte = b;
    r.frame_sequence = s;
    r.frame_time = t;
    r.last_of_run = l;
    r.stat_value = v;
    r.fault_latched = fault;
    return r;
  endfunction

  task automatic close_frame();
    int used;
    int slot;
    if (!cap_taint) begin
      if ((cap_buf[0] & HDR_MASK) != HDR_GOOD) begin
        stat_cnt[CNT_BAD]++;
        if (bad_row < BAD_LIMIT) bad_row++;
        if (bad_row >= BAD_LIMIT && !fault) begin
          fault = 1'b1;
          fault_events++;
        end
      end else begin
        used = ring_fill();
        bad_row = '0;
        stat_cnt[CNT_GOOD]++;
        if (used >= QD) begin
          stat_cnt[CNT_DROPS]++;
        end else begin
          slot = wr_cnt % QD;
          for (int i = 0; i < FB; i++) ring_mem[slot * FB + i] = cap_buf[i];
          ring_seq[slot] = cap_seq;
          ring_tm[slot] = cap_tm;
          wr_cnt = (wr_cnt + 1) % (2 * QD);
          if (used + 1 > stat_cnt[CNT_PEAK]) stat_cnt[CNT_PEAK] = 32'(used + 1);
        end
      end
    end
    cap_open = 1'b0;
    cap_taint = 1'b0;
    cap_idx = 0;
  endtask

  // Works out what one accepted word does to the ring and which words come back.
  task automatic frame_ring_step(input stim_t w);
    int slot;
    logic [31:0] v;
    case (w.op)
      OP_EDGE: begin
        if (cap_en) begin
          stat_cnt[CNT_EDGES]++;
          if (!fault) begin
            if (cap_open) begin
              stat_cnt[CNT_BUSY]++;
              cap_taint = 1'b1;
            end else begin
              cap_open = 1'b1;
              cap_taint = 1'b0;
              cap_idx = 0;
              cap_tm = w.stamp;
              cap_seq = stat_cnt[CNT_EDGES];
            end
          end
        end
      end
      OP_BYTE: begin
        if (cap_open) begin
          cap_buf[cap_idx] = w.data;
          cap_idx++;
          if (cap_idx >= FB) close_frame();
        end
      end
      OP_POP: begin
        if (ring_fill() == 0) begin
          expected_words.push_back(make_word(KIND_EMPTY, '0, '0, '0, 1'b1, '0));
        end else begin
          slot = rd_cnt % QD;
          for (int k = 0; k < FB; k++)
            expected_words.push_back(make_word(KIND_BYTE, ring_mem[slot * FB + k],
                                               ring_seq[slot], ring_tm[slot],
                                               k == FB - 1, '0));
          rd_cnt = (rd_cnt + 1) % (2 * QD);
          frames_popped++;
        end
      end
      OP_STOP: begin
        stat_cnt[CNT_DISCARD] += 32'(ring_fill() + (cap_open ? 1 : 0));
        wr_cnt = 0;
        rd_cnt = 0;
        cap_open = 1'b0;
        cap_taint = 1'b0;
        cap_idx = 0;
        fault = 1'b0;
        bad_row = '0;
      end
      OP_READ: begin
        v = (w.sel == STAT_FAULT) ? {31'd0, fault} : stat_cnt[w.sel];
        expected_words.push_back(make_word(KIND_STAT, '0, '0, '0, 1'b1, v));
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic check_word(input result_t want);
    if (kind !== want.kind) note_mismatch("kind", 64'(kind), 64'(want.kind));
    if (frame_byte !== want.frame_byte)
      note_mismatch("frame_byte", 64'(frame_byte), 64'(want.frame_byte));
    if (frame_sequence !== want.frame_sequence)
      note_mismatch("frame_sequence", 64'(frame_sequence), 64'(want.frame_sequence));
    if (frame_time !== want.frame_time) note_mismatch("frame_time", frame_time, want.frame_time);
    if (last_of_run !== want.last_of_run)
      note_mismatch("last_of_run", 64'(last_of_run), 64'(want.last_of_run));
    if (stat_value !== want.stat_value)
      note_mismatch("stat_value", 64'(stat_value), 64'(want.stat_value));
    if (fault_latched !== want.fault_latched)
      note_mismatch("fault_latched", 64'(fault_latched), 64'(want.fault_latched));
  endtask

  // Sender: offers the next queued word unless it idles this cycle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (cfg_we) cap_en = cfg_wdata;
      if (in_valid && !in_stall) begin
        frame_ring_step(on_bus);
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (stim_words.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          on_bus = stim_words.pop_front();
          in_valid <= 1'b1;
          op <= on_bus.op;
          data_byte <= on_bus.data;
          time_stamp <= on_bus.stamp;
          stat_index <= on_bus.sel;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted word and stalls at random or for a long hold.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_checked++;
        if (expected_words.size() == 0)
          note_mismatch("word with nothing expected", 64'(kind), '0);
        else check_word(expected_words.pop_front());
      end
      if (hold_token != hold_seen) begin
        hold_seen <= hold_token;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Timed out after %0d cycles with no word moving.", QUIET_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic push_word(input logic [2:0] o, input logic [7:0] d, input logic [63:0] t,
                           input logic [2:0] s);
    stim_t w;
    w.op = o;
    w.data = d;
    w.stamp = t;
    w.sel = s;
    stim_words.push_back(w);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // One capture: an edge and n bytes, with another edge before byte taint_at if wanted.
  task automatic queue_frame(input bit hdr_ok, input int taint_at, input int n);
    logic [3:0] nib;
    push_word(OP_EDGE, pick_byte(), {$urandom, $urandom}, 3'($urandom));
    for (int i = 0; i < n; i++) begin
      if (i == taint_at) push_word(OP_EDGE, pick_byte(), {$urandom, $urandom}, 3'($urandom));
      if (i == 0) begin
        nib = 4'($urandom_range(0, 14));
        if (nib >= 4'hC) nib++;
        push_word(OP_BYTE, hdr_ok ? {4'hC, 4'($urandom)} : {nib, 4'($urandom)},
                  {$urandom, $urandom}, 3'($urandom));
      end else begin
        push_word(OP_BYTE, pick_byte(), {$urandom, $urandom}, 3'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (stim_words.size() != 0 || in_valid || expected_words.size() != 0) @(negedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_enable(input logic v);
    settle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    @(negedge clk);
  endtask

  // Mostly whole frames with random content, mixed with pops, reads, stops and noise.
  task automatic random_phase(input int target);
    int n;
    int pick;
    n = 0;
    while (n < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        queue_frame(1'b1, -1, FB);
        n += FB + 1;
      end else if (pick < 52) begin
        queue_frame(1'b0, -1, FB);
        n += FB + 1;
      end else if (pick < 60) begin
        queue_frame(1'($urandom_range(0, 1)), $urandom_range(1, FB - 1), FB);
        n += FB + 2;
      end else if (pick < 64) begin
        queue_frame(1'b1, -1, $urandom_range(1, FB - 1));
        n += 2;
      end else if (pick < 78) begin
        push_word(OP_POP, pick_byte(), {$urandom, $urandom}, 3'($urandom));
        n++;
      end else if (pick < 86) begin
        push_word(OP_READ, pick_byte(), {$urandom, $urandom}, 3'($urandom));
        n++;
      end else if (pick < 89) begin
        push_word(OP_STOP, pick_byte(), {$urandom, $urandom}, 3'($urandom));
        n++;
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 3))
          push_word(3'($urandom_range(0, OP_LAST)), pick_byte(), {$urandom, $urandom},
                    3'($urandom));
      end else begin
        wait_drained();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Capture disabled: edges are ignored, stray bytes find no capture; then a pop, reads, unused codes and a stop.
    push_word(OP_EDGE, 8'hFF, '1, 3'd7);
    push_word(OP_BYTE, 8'hFF, '1, 3'd7);
    push_word(OP_POP, 8'h00, '0, 3'd0);
    for (int s = 0; s <= OP_LAST; s++) push_word(OP_READ, 8'h00, '0, 3'(s));
    for (int c = OP_READ + 1; c <= OP_LAST; c++) push_word(3'(c), 8'hFF, '1, 3'd7);
    push_word(OP_STOP, 8'h00, '0, 3'd0);

    // Another edge taints the open capture, and stop discards it.
    write_enable(1'b1);
    push_word(OP_EDGE, 8'h00, '0, 3'd0);
    push_word(OP_EDGE, 8'hFF, '1, 3'd7);
    push_word(OP_STOP, 8'h00, '0, 3'd0);
    push_word(OP_READ, 8'h00, '0, CNT_BUSY);
    push_word(OP_READ, 8'h00, '0, CNT_DISCARD);

    random_phase(24);
    push_word(OP_STOP, 8'h00, '0, 3'd0);
    queue_frame(1'b1, -1, 10);

    // Disabled mid-capture: the open capture still completes.
    write_enable(1'b0);
    push_word(OP_EDGE, 8'h00, {$urandom, $urandom}, 3'd0);
    repeat (FB - 10 + 3) push_word(OP_BYTE, pick_byte(), '0, 3'd0);
    push_word(OP_READ, 8'h00, '0, CNT_EDGES);
    push_word(OP_POP, 8'h00, '0, 3'd0);
    push_word(OP_POP, 8'h00, '0, 3'd0);
    push_word(OP_READ, 8'h00, '0, CNT_GOOD);

    // Receiver held off while a frame pop and statistic reads pile up behind it.
    write_enable(1'b1);
    steady = 1'b1;
    push_word(OP_STOP, 8'h00, '0, 3'd0);
    wait_drained();
    hold_token++;
    queue_frame(1'b1, -1, FB);
    repeat (2) push_word(OP_POP, 8'h00, '0, 3'd0);
    for (int s = 0; s <= OP_LAST; s++) push_word(OP_READ, 8'h00, '0, 3'(s));
    wait_drained();

    // A bad streak latches the fault; edges then open nothing until a stop.
    repeat (3) queue_frame(1'b0, -1, FB);
    queue_frame(1'b1, -1, 5);
    push_word(OP_READ, 8'h00, '0, STAT_FAULT);
    push_word(OP_READ, 8'h00, '0, CNT_EDGES);
    push_word(OP_STOP, 8'h00, '0, 3'd0);
    push_word(OP_READ, 8'h00, '0, STAT_FAULT);
    push_word(OP_READ, 8'h00, '0, CNT_BAD);
    settle();
    steady = 1'b0;

    write_enable(1'b0);
    settle();

    $display("Run moved %0d input words and %0d result words, %0d frames read back.",
             words_taken, words_checked, frames_popped);
    $display("Enable written %0d times; peak fill %0d, drops %0d, fault latched %0d times.",
             cfg_writes, stat_cnt[CNT_PEAK], stat_cnt[CNT_DROPS], fault_events);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
